[hw/rtl/tds_pkg.sv]
// ----------------------------------------------------------------------------
// tds_pkg: shared definitions for the template delimiter scanner
// Field widths, request and result codes, reset values of the registers and
// the HTML entity table used on substituted value bytes.
// ----------------------------------------------------------------------------
package tds_pkg;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 2;
    localparam int LEN_W      = 3;   // delimiter length register
    localparam int MC_W       = 3;   // delimiter match count
    localparam int NL_W       = 6;   // name length
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // defaults for the top level parameters
    localparam int DELIM_MAX_DEF = 4;
    localparam int NAME_MAX_DEF  = 32;

    // register reset values: "{{" and "}}"
    localparam logic [CFG_DATA_W-1:0] OPEN_BYTES_RST  = 32'h0000_7B7B;
    localparam logic [CFG_DATA_W-1:0] CLOSE_BYTES_RST = 32'h0000_7D7D;
    localparam logic [LEN_W-1:0]      DELIM_LEN_RST   = 3'd2;

    // request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_TEMPLATE = 2'd0,
        MODE_VALUE    = 2'd1,
        MODE_FLUSH    = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TEXT  = 2'd0,
        KIND_NAME  = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_BYTES  = 3'd0,
        REG_OPEN_LEN    = 3'd1,
        REG_CLOSE_BYTES = 3'd2,
        REG_CLOSE_LEN   = 3'd3,
        REG_ESCAPE      = 3'd4
    } cfg_reg_t;

    // characters that get an entity
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
    localparam logic [BYTE_W-1:0] CH_QUOT  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;

    // number of output bytes for one escaped value byte
    function automatic logic [2:0] esc_len(input logic [BYTE_W-1:0] c);
        logic [2:0] n;
        case (c)
            CH_LT, CH_GT:    n = 3'd4;
            CH_AMP:          n = 3'd5;
            CH_QUOT, CH_APOS: n = 3'd6;
            default:         n = 3'd1;
        endcase
        return n;
    endfunction

    // character i of the entity for c; plain c when c has no entity
    function automatic logic [BYTE_W-1:0] esc_char(input logic [BYTE_W-1:0] c,
                                                   input logic [2:0] i);
        logic [47:0] s;
        logic        hit;
        hit = 1'b1;
        case (c)
            CH_LT:   s = {"&lt;", 16'h0000};
            CH_GT:   s = {"&gt;", 16'h0000};
            CH_AMP:  s = {"&amp;", 8'h00};
            CH_QUOT: s = "&quot;";
            CH_APOS: s = "&#x27;";
            default:
            begin
                s   = '0;
                hit = 1'b0;
            end
        endcase
        if (!hit || i > 3'd5)
        begin
            return c;
        end
        return s[8 * (5 - int'(i)) +: 8];
    endfunction

endpackage

[hw/rtl/tds_if.sv]
// ----------------------------------------------------------------------------
// tds_if: channel interfaces of the template delimiter scanner
// Input request channel, result channel and register write channel, each
// with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface tds_item_if;
    logic                       valid;
    logic                       ready;
    logic [tds_pkg::MODE_W-1:0] mode;
    logic [tds_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output mode, output in_byte, input ready);
    modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

interface tds_result_if;
    logic                       valid;
    logic                       ready;
    logic [tds_pkg::KIND_W-1:0] out_kind;
    logic [tds_pkg::BYTE_W-1:0] out_byte;
    logic                       out_last;

    modport source (output valid, output out_kind, output out_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_last,
                    output ready);
endinterface

interface tds_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tds_pkg::CFG_IDX_W-1:0]  index;
    logic [tds_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/template_delimiter_scanner.sv]
// ----------------------------------------------------------------------------
// template_delimiter_scanner: template text scanner with name extraction
// Passes literal text, collects names between start and end delimiters and
// escapes substituted value bytes as HTML entities when escaping is on.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one request per handshake (template byte, value byte or flush).
//   result : text bytes, name bytes or an empty-name marker; out_last is set
//            on the last result of a request.
//   cfg    : register writes, always ready; write only while the block idles.
// Flow: the block takes one request at a time and drops item.ready until
//   the request is done. Each name byte takes two steps, set by the read
//   port of the name RAM (request, then registered data). The last result
//   of a request sits in a holding register and goes out in the closing
//   step of the request.
// Reset: scanner returns to text phase, registers take "{{", "}}", length 2
//   and escaping on. Name RAM contents are not cleared.
// Stall: when result.ready is low the output register holds; the sequencer
//   stops at the next result it has to hand over.
// ----------------------------------------------------------------------------
module template_delimiter_scanner #(
    parameter int DELIM_MAX = tds_pkg::DELIM_MAX_DEF,
    parameter int NAME_MAX  = tds_pkg::NAME_MAX_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tds_item_if.sink      item,
    tds_result_if.source  result,
    tds_cfg_if.sink       cfg
);

    localparam int LW = tds_pkg::LEN_W;
    localparam int MW = tds_pkg::MC_W;
    localparam int NW = tds_pkg::NL_W;
    localparam int BW = tds_pkg::BYTE_W;
    localparam int AW = $clog2(NAME_MAX);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TMATCH,
        S_VAL,
        S_OPFX,
        S_CPUT,
        S_NRD,
        S_NEM,
        S_FOPEN,
        S_FCLS,
        S_FIN
    } state_t;

    // registers
    state_t                        state_reg;
    logic [tds_pkg::CFG_DATA_W-1:0] open_bytes_reg;
    logic [tds_pkg::CFG_DATA_W-1:0] close_bytes_reg;
    logic [LW-1:0]                 open_len_reg;
    logic [LW-1:0]                 close_len_reg;
    logic                          escape_reg;
    logic                          phase_reg;
    logic [MW-1:0]                 mc_reg;
    logic [NW-1:0]                 nl_reg;
    logic [NW-1:0]                 idx_reg;
    logic                          flush_reg;
    logic [BW-1:0]                 byte_reg;
    logic                          pend_valid_reg;
    tds_pkg::kind_t                pend_kind_reg;
    logic [BW-1:0]                 pend_byte_reg;
    logic                          out_valid_reg;
    tds_pkg::kind_t                out_kind_reg;
    logic [BW-1:0]                 out_byte_reg;
    logic                          out_last_reg;

    // combinational
    logic [LW-1:0]       ol;
    logic [LW-1:0]       cl;
    logic                pass;
    logic                hit;
    logic [MW:0]         mc_plus;
    logic [NW-1:0]       idx_plus;
    logic [2:0]          val_len;
    logic                sel_close;
    logic [MW-1:0]       sel_idx;
    logic [BW-1:0]       dsel_ch;
    logic                dsel_eq;
    logic                gen_valid;
    tds_pkg::kind_t      gen_kind;
    logic [BW-1:0]       gen_byte;
    logic                out_free;
    logic                stall;
    logic                adv;
    logic                item_fire;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [BW-1:0]       ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [BW-1:0]       ram_rdata;

    // length above the limit counts as the limit
    function automatic logic [LW-1:0] clamp_len(input logic [LW-1:0] len);
        return (int'(len) > DELIM_MAX) ? LW'(DELIM_MAX) : len;
    endfunction

    assign ol       = clamp_len(open_len_reg);
    assign cl       = clamp_len(close_len_reg);
    assign pass     = (ol == '0) || (cl == '0);
    assign mc_plus  = {1'b0, mc_reg} + {{MW{1'b0}}, 1'b1};
    assign idx_plus = idx_reg + {{(NW-1){1'b0}}, 1'b1};
    assign val_len  = escape_reg ? tds_pkg::esc_len(byte_reg) : 3'd1;
    assign hit      = (mc_reg < (phase_reg ? cl : ol)) && dsel_eq;

    // handshake
    assign item.ready    = (state_reg == S_IDLE);
    assign item_fire     = item.valid && item.ready;
    assign cfg.ready     = 1'b1;
    assign out_free      = !out_valid_reg || result.ready;
    assign stall         = gen_valid && pend_valid_reg && !out_free;
    assign adv           = !stall;

    assign result.valid    = out_valid_reg;
    assign result.out_kind = out_kind_reg;
    assign result.out_byte = out_byte_reg;
    assign result.out_last = out_last_reg;

    // shared delimiter select / compare unit
    tds_dsel u_dsel (
        .bytes (sel_close ? close_bytes_reg : open_bytes_reg),
        .idx   (sel_idx),
        .cmp   (byte_reg),
        .ch    (dsel_ch),
        .eq    (dsel_eq)
    );

    // name store
    tds_ram #(
        .WIDTH (BW),
        .DEPTH (NAME_MAX)
    ) u_name_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // per-step result generation and name store access
    always_comb
    begin
        gen_valid = 1'b0;
        gen_kind  = tds_pkg::KIND_TEXT;
        gen_byte  = byte_reg;
        sel_close = 1'b0;
        sel_idx   = idx_reg[MW-1:0];
        ram_we    = 1'b0;
        ram_waddr = nl_reg[AW-1:0];
        ram_wdata = byte_reg;
        ram_re    = 1'b0;
        ram_raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_TMATCH:
            begin
                sel_close = phase_reg;
                sel_idx   = mc_reg;
                if (pass)
                begin
                    gen_valid = 1'b1;
                end
                else if (!phase_reg)
                begin
                    gen_valid = !hit && (mc_reg == '0);
                end
                else if (hit)
                begin
                    if ((mc_plus >= {1'b0, cl}) && (nl_reg == '0))
                    begin
                        gen_valid = 1'b1;
                        gen_kind  = tds_pkg::KIND_EMPTY;
                        gen_byte  = '0;
                    end
                end
                else if ((mc_reg == '0) && (int'(nl_reg) < NAME_MAX))
                begin
                    ram_we = 1'b1;
                end
            end
            S_VAL:
            begin
                gen_valid = 1'b1;
                gen_byte  = escape_reg ? tds_pkg::esc_char(byte_reg, idx_reg[2:0])
                                       : byte_reg;
            end
            S_OPFX, S_FOPEN:
            begin
                gen_valid = 1'b1;
                gen_byte  = dsel_ch;
            end
            S_CPUT:
            begin
                sel_close = 1'b1;
                ram_wdata = dsel_ch;
                ram_we    = (int'(nl_reg) < NAME_MAX);
            end
            S_FCLS:
            begin
                sel_close = 1'b1;
                gen_valid = 1'b1;
                gen_byte  = dsel_ch;
            end
            S_NRD:
            begin
                ram_re = 1'b1;
            end
            S_NEM:
            begin
                gen_valid = 1'b1;
                gen_kind  = flush_reg ? tds_pkg::KIND_TEXT : tds_pkg::KIND_NAME;
                gen_byte  = ram_rdata;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, registers and output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            open_bytes_reg  <= tds_pkg::OPEN_BYTES_RST;
            close_bytes_reg <= tds_pkg::CLOSE_BYTES_RST;
            open_len_reg    <= tds_pkg::DELIM_LEN_RST;
            close_len_reg   <= tds_pkg::DELIM_LEN_RST;
            escape_reg      <= 1'b1;
            phase_reg       <= 1'b0;
            mc_reg          <= '0;
            nl_reg          <= '0;
            idx_reg         <= '0;
            flush_reg       <= 1'b0;
            byte_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            pend_kind_reg   <= tds_pkg::KIND_TEXT;
            pend_byte_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= tds_pkg::KIND_TEXT;
            out_byte_reg    <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg.valid)
            begin
                case (cfg.index)
                    tds_pkg::REG_OPEN_BYTES:  open_bytes_reg  <= cfg.data;
                    tds_pkg::REG_OPEN_LEN:    open_len_reg    <= cfg.data[LW-1:0];
                    tds_pkg::REG_CLOSE_BYTES: close_bytes_reg <= cfg.data;
                    tds_pkg::REG_CLOSE_LEN:   close_len_reg   <= cfg.data[LW-1:0];
                    tds_pkg::REG_ESCAPE:      escape_reg      <= cfg.data[0];
                    default:
                    begin
                    end
                endcase
            end

            // output register drains
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // new result goes to holding register, older one moves out
            if (gen_valid && adv)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_kind_reg  <= pend_kind_reg;
                    out_byte_reg  <= pend_byte_reg;
                    out_last_reg  <= 1'b0;
                end
                pend_valid_reg <= 1'b1;
                pend_kind_reg  <= gen_kind;
                pend_byte_reg  <= gen_byte;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_fire)
                    begin
                        byte_reg  <= item.in_byte;
                        idx_reg   <= '0;
                        flush_reg <= 1'b0;
                        case (item.mode)
                            tds_pkg::MODE_TEMPLATE: state_reg <= S_TMATCH;
                            tds_pkg::MODE_VALUE:    state_reg <= S_VAL;
                            tds_pkg::MODE_FLUSH:
                            begin
                                flush_reg <= 1'b1;
                                if (!phase_reg)
                                begin
                                    state_reg <= (mc_reg == '0) ? S_FIN : S_OPFX;
                                end
                                else if (ol != '0)
                                begin
                                    state_reg <= S_FOPEN;
                                end
                                else if (nl_reg != '0)
                                begin
                                    state_reg <= S_NRD;
                                end
                                else if (mc_reg != '0)
                                begin
                                    state_reg <= S_FCLS;
                                end
                                else
                                begin
                                    state_reg <= S_FIN;
                                end
                            end
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end

                // examine the current template byte
                S_TMATCH:
                begin
                    if (adv)
                    begin
                        state_reg <= S_FIN;
                        if (pass)
                        begin
                        end
                        else if (!phase_reg)
                        begin
                            if (hit)
                            begin
                                if (mc_plus >= {1'b0, ol})
                                begin
                                    phase_reg <= 1'b1;
                                    nl_reg    <= '0;
                                    mc_reg    <= '0;
                                end
                                else
                                begin
                                    mc_reg <= mc_plus[MW-1:0];
                                end
                            end
                            else if (mc_reg != '0)
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_OPFX;
                            end
                        end
                        else if (hit)
                        begin
                            if (mc_plus >= {1'b0, cl})
                            begin
                                phase_reg <= 1'b0;
                                mc_reg    <= '0;
                                if (nl_reg != '0)
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= S_NRD;
                                end
                            end
                            else
                            begin
                                mc_reg <= mc_plus[MW-1:0];
                            end
                        end
                        else if (mc_reg != '0)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_CPUT;
                        end
                        else if (int'(nl_reg) < NAME_MAX)
                        begin
                            nl_reg <= nl_reg + {{(NW-1){1'b0}}, 1'b1};
                        end
                        else
                        begin
                            // name overflow: drop it
                            phase_reg <= 1'b0;
                            mc_reg    <= '0;
                        end
                    end
                end

                // escaped value byte
                S_VAL:
                begin
                    if (adv)
                    begin
                        if (idx_plus >= {{(NW-3){1'b0}}, val_len})
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            idx_reg <= idx_plus;
                        end
                    end
                end

                // failed start match: emit prefix
                S_OPFX:
                begin
                    if (adv)
                    begin
                        if (idx_plus >= {{(NW-MW){1'b0}}, mc_reg})
                        begin
                            mc_reg    <= '0;
                            state_reg <= flush_reg ? S_FIN : S_TMATCH;
                        end
                        else
                        begin
                            idx_reg <= idx_plus;
                        end
                    end
                end

                // failed end match: put prefix back into the name
                S_CPUT:
                begin
                    if (int'(nl_reg) < NAME_MAX)
                    begin
                        nl_reg <= nl_reg + {{(NW-1){1'b0}}, 1'b1};
                    end
                    if ((idx_plus >= {{(NW-MW){1'b0}}, mc_reg}) ||
                        (int'(nl_reg) >= NAME_MAX - 1))
                    begin
                        mc_reg    <= '0;
                        state_reg <= S_TMATCH;
                    end
                    else
                    begin
                        idx_reg <= idx_plus;
                    end
                end

                // name byte read request
                S_NRD:
                begin
                    state_reg <= S_NEM;
                end

                // name byte out
                S_NEM:
                begin
                    if (adv)
                    begin
                        if (idx_plus >= nl_reg)
                        begin
                            idx_reg <= '0;
                            if (flush_reg && (mc_reg != '0))
                            begin
                                state_reg <= S_FCLS;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                        else
                        begin
                            idx_reg   <= idx_plus;
                            state_reg <= S_NRD;
                        end
                    end
                end

                // flush: start delimiter
                S_FOPEN:
                begin
                    if (adv)
                    begin
                        if (idx_plus >= {{(NW-LW){1'b0}}, ol})
                        begin
                            idx_reg <= '0;
                            if (nl_reg != '0)
                            begin
                                state_reg <= S_NRD;
                            end
                            else if (mc_reg != '0)
                            begin
                                state_reg <= S_FCLS;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                        else
                        begin
                            idx_reg <= idx_plus;
                        end
                    end
                end

                // flush: partial end delimiter
                S_FCLS:
                begin
                    if (adv)
                    begin
                        if (idx_plus >= {{(NW-MW){1'b0}}, mc_reg})
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            idx_reg <= idx_plus;
                        end
                    end
                end

                // hand over the last result, close the request
                S_FIN:
                begin
                    if (flush_reg)
                    begin
                        phase_reg <= 1'b0;
                        nl_reg    <= '0;
                        mc_reg    <= '0;
                    end
                    if (pend_valid_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_kind_reg   <= pend_kind_reg;
                            out_byte_reg   <= pend_byte_reg;
                            out_last_reg   <= 1'b1;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // a new request never starts with a result still held back
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !pend_valid_reg)
        else $error("request accepted with a held result");

    // name reads stay inside the stored name
    a_name_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NEM) |-> (idx_reg < nl_reg))
        else $error("name read beyond name length");

    // name length never passes the store size
    a_name_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (int'(nl_reg) <= NAME_MAX))
        else $error("name length beyond store size");

    // a name read request is always followed by its data step
    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NRD) |=> (state_reg == S_NEM))
        else $error("name read without data step");
`endif

endmodule

[hw/rtl/tds_ram.sv]
// ----------------------------------------------------------------------------
// tds_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/tds_dsel.sv]
// ----------------------------------------------------------------------------
// tds_dsel: delimiter character select and compare
// Picks character idx of a packed delimiter word (zero past the last one)
// and compares it with the current byte. Shared by all delimiter steps.
// ----------------------------------------------------------------------------
module tds_dsel (
    input  logic [tds_pkg::CFG_DATA_W-1:0] bytes,
    input  logic [tds_pkg::MC_W-1:0]       idx,
    input  logic [tds_pkg::BYTE_W-1:0]     cmp,
    output logic [tds_pkg::BYTE_W-1:0]     ch,
    output logic                           eq
);

    localparam int NCHAR = tds_pkg::CFG_DATA_W / tds_pkg::BYTE_W;
    localparam int MW    = tds_pkg::MC_W;

    // characters beyond the word read as zero
    assign ch = (idx < MW'(NCHAR)) ? bytes[{idx[1:0], 3'b000} +: 8] : '0;
    assign eq = (ch == cmp);

endmodule
